[rtl/stm_pkg.sv]
// ----------------------------------------------------------------------------
// stm_pkg
// Types, constants and helpers shared by the scanner to machine transform.
// ----------------------------------------------------------------------------
package stm_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FIELD_W         = 32;
    localparam int TRIG_W          = 18;
    localparam int CFG_IDX_W       = 3;
    localparam int ARG_W           = 72;
    localparam int ROOT_W          = ARG_W / 2;
    localparam int REM_W           = ROOT_W + 2;
    localparam int SQRT_STEPS      = 2;
    localparam int SQRT_STAGES     = ROOT_W / SQRT_STEPS;
    localparam int HORIZ_W         = FIELD_W + 2;
    localparam int SAT_W           = 40;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SINE    = 3'd0,
        REG_COSINE  = 3'd1,
        REG_HOFF    = 3'd2,
        REG_OFF_Y   = 3'd3,
        REG_OFF_Z   = 3'd4,
        REG_CENTRE_Y = 3'd5,
        REG_CENTRE_Z = 3'd6,
        REG_CAL     = 3'd7
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_LASER  = 2'd1,
        ST_NO_OBJECT = 2'd2,
        ST_NEG_ROOT  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  sine;
        logic signed [TRIG_W-1:0]  cosine;
        logic signed [FIELD_W-1:0] hoff;
        logic signed [FIELD_W-1:0] off_y;
        logic signed [FIELD_W-1:0] off_z;
        logic signed [FIELD_W-1:0] centre_y;
        logic signed [FIELD_W-1:0] centre_z;
        logic [1:0]                cal;
    } cfg_t;

    typedef struct packed {
        logic                      last;
        logic                      neg;
        logic signed [HORIZ_W-1:0] horiz;
    } side_t;

    function automatic logic signed [FIELD_W-1:0] saturate(
        input logic signed [SAT_W-1:0] v,
        input int                      w
    );
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = (SAT_W'(1) <<< (w - 1)) - SAT_W'(1);
        lo = -hi - SAT_W'(1);
        if (v > hi)
        begin
            return FIELD_W'(hi);
        end
        if (v < lo)
        begin
            return FIELD_W'(lo);
        end
        return FIELD_W'(v);
    endfunction

endpackage

[rtl/stm_if.sv]
// ----------------------------------------------------------------------------
// stm interfaces
// Point, coordinate and register write channels.
// ----------------------------------------------------------------------------
interface stm_point_if
    import stm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] laser_x;
    logic signed [FIELD_W-1:0] laser_y;
    logic signed [FIELD_W-1:0] axis_horizontal;
    logic signed [FIELD_W-1:0] axis_vertical;
    logic                      last_point;

    modport source (output valid, laser_x, laser_y, axis_horizontal, axis_vertical,
                    last_point, input ready);
    modport sink (input valid, laser_x, laser_y, axis_horizontal, axis_vertical,
                  last_point, output ready);
endinterface

interface stm_coord_if
    import stm_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] machine_horizontal;
    logic signed [FIELD_W-1:0] machine_vertical;
    logic [1:0]                status;
    logic                      last_out;

    modport source (output valid, machine_horizontal, machine_vertical, status,
                    last_out, input ready);
    modport sink (input valid, machine_horizontal, machine_vertical, status,
                  last_out, output ready);
endinterface

interface stm_cfg_if
    import stm_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [FIELD_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/stm_front.sv]
// ----------------------------------------------------------------------------
// stm_front
// Rotation, offsets and root argument, four register stages.
// ----------------------------------------------------------------------------
module stm_front
    import stm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [FIELD_W-1:0] laser_x,
    input  logic signed [FIELD_W-1:0] laser_y,
    input  logic signed [FIELD_W-1:0] axis_horizontal,
    input  logic signed [FIELD_W-1:0] axis_vertical,
    input  logic                      last_point,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ARG_W-1:0]          out_arg,
    output side_t                     out_side
);

    localparam int PROD_W = FIELD_W + TRIG_W;
    localparam int ROT_W  = PROD_W - 15;
    localparam int DIF_W  = FIELD_W + 7;
    localparam int MAG_W  = 38;
    localparam int HALF_W = MAG_W / 2;
    localparam int PP_W   = 2 * HALF_W;
    localparam int SQ_W   = 2 * MAG_W;

    logic [3:0] v_reg;
    logic [3:0] rdy;

    // stage 1
    logic signed [PROD_W-1:0]  ps_reg, pc_reg;
    logic signed [FIELD_W-1:0] av_reg;
    side_t                     s1_reg;
    // stage 2
    logic [MAG_W-1:0]          my_reg, mz_reg;
    logic [FIELD_W-1:0]        mc_reg;
    side_t                     s2_reg;
    // stage 3
    logic [PP_W-1:0]           yll_reg, ylh_reg, yhh_reg, zll_reg, zlh_reg, zhh_reg;
    logic [2*FIELD_W-1:0]      cc_reg;
    side_t                     s3_reg;
    // stage 4
    logic [ARG_W-1:0]          arg_reg;
    side_t                     s4_reg;

    logic signed [PROD_W:0]    ty, tz;
    logic signed [ROT_W-1:0]   ry, rz;
    logic signed [DIF_W-1:0]   dy, dz, pz;
    logic [FIELD_W-1:0]        mc;
    logic [SQ_W-1:0]           sqy, sqz;
    logic [SQ_W:0]             sum;

    assign rdy[3]   = !v_reg[3] || out_ready;
    assign rdy[2]   = !v_reg[2] || rdy[3];
    assign rdy[1]   = !v_reg[1] || rdy[2];
    assign rdy[0]   = !v_reg[0] || rdy[1];
    assign in_ready = rdy[0];

    always_comb
    begin
        ty  = (PROD_W+1)'(ps_reg) + (PROD_W+1)'(32768);
        tz  = (PROD_W+1)'(pc_reg) + (PROD_W+1)'(32768);
        ry  = ty[PROD_W:16];
        rz  = tz[PROD_W:16];
        dy  = DIF_W'(ry) + DIF_W'(cfg.off_y) - DIF_W'(cfg.centre_y);
        pz  = DIF_W'(rz) + DIF_W'(cfg.off_z) + DIF_W'(av_reg);
        dz  = pz - DIF_W'(cfg.centre_z);
        mc  = cfg.centre_y[FIELD_W-1] ? FIELD_W'(-(FIELD_W+1)'(cfg.centre_y))
                                      : FIELD_W'(cfg.centre_y);
        sqy = (SQ_W'(yhh_reg) << (2*HALF_W)) + (SQ_W'(ylh_reg) << (HALF_W+1))
              + SQ_W'(yll_reg);
        sqz = (SQ_W'(zhh_reg) << (2*HALF_W)) + (SQ_W'(zlh_reg) << (HALF_W+1))
              + SQ_W'(zll_reg);
        sum = (SQ_W+1)'(sqy) + (SQ_W+1)'(sqz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ps_reg <= laser_y * cfg.sine;
            pc_reg <= laser_y * cfg.cosine;
            av_reg <= axis_vertical;
            s1_reg <= '{last:  last_point,
                        neg:   1'b0,
                        horiz: HORIZ_W'(axis_horizontal) + HORIZ_W'(cfg.hoff)
                               - HORIZ_W'(laser_x)};
        end
        if (rdy[1])
        begin
            my_reg <= dy[DIF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
            mz_reg <= dz[DIF_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
            mc_reg <= mc;
            s2_reg <= s1_reg;
        end
        if (rdy[2])
        begin
            yll_reg <= my_reg[HALF_W-1:0] * my_reg[HALF_W-1:0];
            ylh_reg <= my_reg[HALF_W-1:0] * my_reg[MAG_W-1:HALF_W];
            yhh_reg <= my_reg[MAG_W-1:HALF_W] * my_reg[MAG_W-1:HALF_W];
            zll_reg <= mz_reg[HALF_W-1:0] * mz_reg[HALF_W-1:0];
            zlh_reg <= mz_reg[HALF_W-1:0] * mz_reg[MAG_W-1:HALF_W];
            zhh_reg <= mz_reg[MAG_W-1:HALF_W] * mz_reg[MAG_W-1:HALF_W];
            cc_reg  <= mc_reg * mc_reg;
            s3_reg  <= s2_reg;
        end
        if (rdy[3])
        begin
            arg_reg <= ARG_W'(sum - (SQ_W+1)'(cc_reg));
            s4_reg  <= '{last:  s3_reg.last,
                         neg:   sum < (SQ_W+1)'(cc_reg),
                         horiz: s3_reg.horiz};
        end
    end

    assign out_valid = v_reg[3];
    assign out_arg   = arg_reg;
    assign out_side  = s4_reg;

endmodule

[rtl/stm_sqrt.sv]
// ----------------------------------------------------------------------------
// stm_sqrt
// Pipelined restoring square root, two result bits per stage.
// ----------------------------------------------------------------------------
module stm_sqrt
    import stm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [ARG_W-1:0]  in_arg,
    input  side_t             in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ROOT_W-1:0] out_root,
    output logic [REM_W-1:0]  out_rem,
    output side_t             out_side
);

    logic [SQRT_STAGES-1:0] v_reg;
    logic [SQRT_STAGES:0]   rdy;
    logic [ARG_W-1:0]       arg_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0]      root_reg [SQRT_STAGES];
    logic [REM_W-1:0]       rem_reg  [SQRT_STAGES];
    side_t                  side_reg [SQRT_STAGES];

    assign rdy[SQRT_STAGES] = out_ready;
    assign in_ready         = rdy[0];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        logic [ARG_W-1:0]  a_in;
        logic [ROOT_W-1:0] r_in;
        logic [REM_W-1:0]  m_in;
        logic              v_in;
        side_t             s_in;
        logic [ARG_W-1:0]  a_nx;
        logic [ROOT_W-1:0] r_nx;
        logic [REM_W-1:0]  m_nx;

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_head
            assign a_in = in_arg;
            assign r_in = '0;
            assign m_in = '0;
            assign v_in = in_valid;
            assign s_in = in_side;
        end
        else
        begin : g_body
            assign a_in = arg_reg[k-1];
            assign r_in = root_reg[k-1];
            assign m_in = rem_reg[k-1];
            assign v_in = v_reg[k-1];
            assign s_in = side_reg[k-1];
        end

        always_comb
        begin
            logic [REM_W+1:0] wr;
            logic [REM_W+1:0] trial;
            a_nx = a_in;
            r_nx = r_in;
            m_nx = m_in;
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                wr    = {m_nx, a_nx[ARG_W-1 -: 2]};
                trial = {(REM_W - ROOT_W)'(0), r_nx, 2'b01};
                a_nx  = a_nx << 2;
                r_nx  = r_nx << 1;
                if (wr >= trial)
                begin
                    wr      = wr - trial;
                    r_nx[0] = 1'b1;
                end
                m_nx = REM_W'(wr);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                arg_reg[k]  <= a_nx;
                root_reg[k] <= r_nx;
                rem_reg[k]  <= m_nx;
                side_reg[k] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign out_root  = root_reg[SQRT_STAGES-1];
    assign out_rem   = rem_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];

endmodule

[rtl/scanner_to_machine_transform.sv]
// ----------------------------------------------------------------------------
// scanner_to_machine_transform
// Laser-plane profile point to machine coordinate, projected onto the
// workpiece circle.
//
//   channel  dir  payload                                         handshake
//   point    in   laser_x laser_y axis_horizontal axis_vertical   valid/ready
//                 last_point
//   coord    out  machine_horizontal machine_vertical status      valid/ready
//                 last_out
//   cfg      in   index data                                      valid/ready
//
// One word per cycle; the path runs through four front stages, eighteen root
// stages (two root bits each) and the output register.
// Reset clears the valid bits and loads the register defaults.
// A stall holds each full stage; empty stages still fill, so bubbles close up.
// cfg is always ready.
// ----------------------------------------------------------------------------
module scanner_to_machine_transform
    import stm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic         clk,
    input logic         rst_n,
    stm_point_if.sink   point,
    stm_coord_if.source coord,
    stm_cfg_if.sink     cfg
);

    localparam int SAT_USE = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;

    cfg_t                cfg_reg;
    logic                f_valid, f_ready, q_valid, q_ready;
    logic [ARG_W-1:0]    f_arg;
    side_t               f_side, q_side;
    logic [ROOT_W-1:0]   q_root;
    logic [REM_W-1:0]    q_rem;
    logic                out_v_reg;
    logic signed [FIELD_W-1:0] mh_reg, mv_reg;
    logic [1:0]          st_reg;
    logic                last_reg;
    logic [ROOT_W:0]     root_rnd;
    logic signed [SAT_W-1:0] vert;
    status_t             st_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sine:     '0,
                         cosine:   TRIG_W'(65536),
                         hoff:     '0,
                         off_y:    '0,
                         off_z:    '0,
                         centre_y: '0,
                         centre_z: '0,
                         cal:      '0};
        end
        else if (cfg.valid)
        begin
            unique case (reg_idx_t'(cfg.index))
                REG_SINE:     cfg_reg.sine     <= cfg.data[TRIG_W-1:0];
                REG_COSINE:   cfg_reg.cosine   <= cfg.data[TRIG_W-1:0];
                REG_HOFF:     cfg_reg.hoff     <= cfg.data;
                REG_OFF_Y:    cfg_reg.off_y    <= cfg.data;
                REG_OFF_Z:    cfg_reg.off_z    <= cfg.data;
                REG_CENTRE_Y: cfg_reg.centre_y <= cfg.data;
                REG_CENTRE_Z: cfg_reg.centre_z <= cfg.data;
                REG_CAL:      cfg_reg.cal      <= cfg.data[1:0];
                default:      ;
            endcase
        end
    end

    stm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (point.valid),
        .in_ready        (point.ready),
        .laser_x         (point.laser_x),
        .laser_y         (point.laser_y),
        .axis_horizontal (point.axis_horizontal),
        .axis_vertical   (point.axis_vertical),
        .last_point      (point.last_point),
        .out_valid       (f_valid),
        .out_ready       (f_ready),
        .out_arg         (f_arg),
        .out_side        (f_side)
    );

    stm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_arg    (f_arg),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_root  (q_root),
        .out_rem   (q_rem),
        .out_side  (q_side)
    );

    assign q_ready = !out_v_reg || coord.ready;

    always_comb
    begin
        root_rnd = (ROOT_W+1)'(q_root)
                   + (ROOT_W+1)'((REM_W)'(q_rem) > REM_W'(q_root));
        vert     = SAT_W'(cfg_reg.centre_z) + SAT_W'(root_rnd);
        if (!cfg_reg.cal[0])
        begin
            st_next = ST_NO_LASER;
        end
        else if (!cfg_reg.cal[1])
        begin
            st_next = ST_NO_OBJECT;
        end
        else if (q_side.neg)
        begin
            st_next = ST_NEG_ROOT;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (q_ready)
        begin
            out_v_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_ready)
        begin
            st_reg   <= st_next;
            last_reg <= q_side.last;
            mh_reg   <= (st_next == ST_OK)
                        ? saturate(SAT_W'(q_side.horiz), SAT_USE) : '0;
            mv_reg   <= (st_next == ST_OK) ? saturate(vert, SAT_USE) : '0;
        end
    end

    assign coord.valid              = out_v_reg;
    assign coord.machine_horizontal = mh_reg;
    assign coord.machine_vertical   = mv_reg;
    assign coord.status             = st_reg;
    assign coord.last_out           = last_reg;

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        coord.valid && coord.status != ST_OK |->
            coord.machine_horizontal == '0 && coord.machine_vertical == '0)
        else $error("failed word carries nonzero coordinates");

    a_no_laser: assert property (@(posedge clk) disable iff (!rst_n)
        coord.valid && !cfg_reg.cal[0] |-> coord.status == ST_NO_LASER)
        else $error("missing laser calibration not reported");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !q_ready |=> q_valid && $stable(q_root))
        else $error("root stage lost a word under stall");

endmodule
